/* design/ple_pkg.sv */
// ---------------------------------------------------------------------------
// ple_pkg: shared definitions for the positional list engine
// Field widths, parameter defaults, command and status codes, sequencer
// states and the control structs passed between the core and its sequencer.
// ---------------------------------------------------------------------------
package ple_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int WIDTH_DEFAULT = 32;

   localparam int CMD_W  = 3;
   localparam int POS_W  = 5;
   localparam int VAL_W  = 32;
   localparam int STAT_W = 2;
   localparam int LEN_W  = 5;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT_AT  = 3'd0,
      CMD_PUSH_FRONT = 3'd1,
      CMD_PUSH_BACK  = 3'd2,
      CMD_REMOVE_AT  = 3'd3,
      CMD_POP_FRONT  = 3'd4,
      CMD_POP_BACK   = 3'd5
   } command_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_EMPTY = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_SHIFT_UP,
      SEQ_PUT,
      SEQ_FETCH,
      SEQ_SHIFT_DOWN
   } seq_state_type;

   typedef struct packed {
      logic start;
      logic grow;
   } seq_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic grow;
   } seq_stat_type;

endpackage

/* design/ple_ram.sv */
// ---------------------------------------------------------------------------
// ple_ram: generic single-clock RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module ple_ram #(
   parameter int DATA_W = 32,
   parameter int DEPTH  = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/ple_seq.sv */
// ---------------------------------------------------------------------------
// ple_seq: entry-move sequencer
// Walks one pointer through the slot memory, moving one entry a cycle to
// open a gap for an insert or to close one after a removal.
// ---------------------------------------------------------------------------
module ple_seq #(
   parameter int DEPTH = ple_pkg::DEPTH_DEFAULT,
   parameter int WIDTH = ple_pkg::WIDTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  ple_pkg::seq_ctrl_type      ctrl,
   input  logic [$clog2(DEPTH)-1:0]   req_index,
   input  logic [$clog2(DEPTH+1)-1:0] used,
   input  logic [WIDTH-1:0]           item,
   output ple_pkg::seq_stat_type      stat,
   output logic [WIDTH-1:0]           taken,
   output logic                       rd_en,
   output logic [$clog2(DEPTH)-1:0]   rd_addr,
   input  logic [WIDTH-1:0]           rd_data,
   output logic                       wr_en,
   output logic [$clog2(DEPTH)-1:0]   wr_addr,
   output logic [WIDTH-1:0]           wr_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   ple_pkg::seq_state_type state_ff, state_in;
   logic [AW-1:0]    ptr_ff, ptr_in;
   logic [AW-1:0]    idx_ff, idx_in;
   logic [WIDTH-1:0] val_ff, val_in;
   logic             grow_ff, grow_in;
   logic [WIDTH-1:0] taken_ff, taken_in;

   logic at_gap;
   logic at_end;
   logic direct_put;
   logic done;

   assign at_gap     = (ptr_ff == idx_ff);
   assign at_end     = ((CW'(ptr_ff) + CW'(1)) == used);
   // Appending at the current end needs no entries moved.
   assign direct_put = ctrl.grow && (CW'(req_index) == used);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ple_pkg::SEQ_IDLE: begin
            if (ctrl.start) begin
               if (!ctrl.grow) begin
                  state_in = ple_pkg::SEQ_FETCH;
               end else if (direct_put) begin
                  state_in = ple_pkg::SEQ_PUT;
               end else begin
                  state_in = ple_pkg::SEQ_SHIFT_UP;
               end
            end
         end
         ple_pkg::SEQ_SHIFT_UP: begin
            if (at_gap) begin
               state_in = ple_pkg::SEQ_PUT;
            end
         end
         ple_pkg::SEQ_PUT: begin
            state_in = ple_pkg::SEQ_IDLE;
         end
         ple_pkg::SEQ_FETCH, ple_pkg::SEQ_SHIFT_DOWN: begin
            state_in = at_end ? ple_pkg::SEQ_IDLE : ple_pkg::SEQ_SHIFT_DOWN;
         end
         default: begin
            state_in = ple_pkg::SEQ_IDLE;
         end
      endcase
   end

   // Each moving cycle writes the entry read in the previous cycle and
   // issues the read of the next one.
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = ptr_ff;
      wr_en   = 1'b0;
      wr_addr = ptr_ff;
      wr_data = rd_data;
      done    = 1'b0;
      case (state_ff)
         ple_pkg::SEQ_IDLE: begin
            if (ctrl.start && !direct_put) begin
               rd_en   = 1'b1;
               rd_addr = ctrl.grow ? AW'(used - CW'(1)) : req_index;
            end
         end
         ple_pkg::SEQ_SHIFT_UP: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff + AW'(1);
            if (!at_gap) begin
               rd_en   = 1'b1;
               rd_addr = ptr_ff - AW'(1);
            end
         end
         ple_pkg::SEQ_PUT: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            wr_data = val_ff;
            done    = 1'b1;
         end
         ple_pkg::SEQ_FETCH: begin
            if (at_end) begin
               done = 1'b1;
            end else begin
               rd_en   = 1'b1;
               rd_addr = ptr_ff + AW'(1);
            end
         end
         ple_pkg::SEQ_SHIFT_DOWN: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff - AW'(1);
            if (at_end) begin
               done = 1'b1;
            end else begin
               rd_en   = 1'b1;
               rd_addr = ptr_ff + AW'(1);
            end
         end
         default: begin
            done = 1'b0;
         end
      endcase
   end

   always_comb begin
      ptr_in   = ptr_ff;
      idx_in   = idx_ff;
      val_in   = val_ff;
      grow_in  = grow_ff;
      taken_in = taken_ff;
      case (state_ff)
         ple_pkg::SEQ_IDLE: begin
            if (ctrl.start) begin
               idx_in  = req_index;
               val_in  = item;
               grow_in = ctrl.grow;
               ptr_in  = ctrl.grow ? AW'(used - CW'(1)) : req_index;
            end
         end
         ple_pkg::SEQ_SHIFT_UP: begin
            if (!at_gap) begin
               ptr_in = ptr_ff - AW'(1);
            end
         end
         ple_pkg::SEQ_FETCH: begin
            taken_in = rd_data;
            if (!at_end) begin
               ptr_in = ptr_ff + AW'(1);
            end
         end
         ple_pkg::SEQ_SHIFT_DOWN: begin
            if (!at_end) begin
               ptr_in = ptr_ff + AW'(1);
            end
         end
         default: begin
            ptr_in = ptr_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ple_pkg::SEQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
      ptr_ff   <= ptr_in;
      idx_ff   <= idx_in;
      val_ff   <= val_in;
      grow_ff  <= grow_in;
      taken_ff <= taken_in;
   end

   // A removal of the last entry finishes in the fetch cycle itself.
   assign taken     = (state_ff == ple_pkg::SEQ_FETCH) ? rd_data : taken_ff;
   assign stat.busy = (state_ff != ple_pkg::SEQ_IDLE);
   assign stat.done = done;
   assign stat.grow = grow_ff;

endmodule

/* design/positional_list_engine_core.sv */
// ---------------------------------------------------------------------------
// positional_list_engine_core: bounded positional list and deque
// Checks each command against the stored count, then lets the sequencer
// move entries in the slot memory and reports one result per request.
// ---------------------------------------------------------------------------
//  Channel   Ports                                   Handshake
//  request   req_command, req_position,              start high, busy low
//            req_item_value
//  result    rsp_removed_value, rsp_status,          rsp_strobe, one cycle
//            rsp_length, rsp_is_empty, rsp_is_full
//
//  A rejected or unknown command gives its result in the cycle after it is
//  taken, and busy stays low. An insert or removal at index p keeps busy
//  high while the entries from index p onward are moved; the single read
//  and write port pair of the slot memory moves one entry a cycle. The
//  result follows in the cycle busy falls.
//  Synchronous reset empties the list; the slot memory is not cleared.
//  The receiver cannot stall; every result is shown for one cycle only.
// ---------------------------------------------------------------------------
module positional_list_engine_core #(
   parameter int DEPTH = ple_pkg::DEPTH_DEFAULT,
   parameter int WIDTH = ple_pkg::WIDTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [ple_pkg::CMD_W-1:0]  req_command,
   input  logic [ple_pkg::POS_W-1:0]  req_position,
   input  logic [ple_pkg::VAL_W-1:0]  req_item_value,
   output logic                       rsp_strobe,
   output logic [ple_pkg::VAL_W-1:0]  rsp_removed_value,
   output logic [ple_pkg::STAT_W-1:0] rsp_status,
   output logic [ple_pkg::LEN_W-1:0]  rsp_length,
   output logic                       rsp_is_empty,
   output logic                       rsp_is_full
);

   localparam int AW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W;

   logic [CW-1:0]               used_ff, used_in;
   logic                        rsp_strobe_ff, rsp_strobe_in;
   logic [ple_pkg::VAL_W-1:0]   rsp_removed_ff, rsp_removed_in;
   ple_pkg::status_type         rsp_status_ff, rsp_status_in;
   logic [ple_pkg::LEN_W-1:0]   rsp_length_ff, rsp_length_in;
   logic                        rsp_empty_ff, rsp_empty_in;
   logic                        rsp_full_ff, rsp_full_in;

   ple_pkg::seq_ctrl_type ctrl;
   ple_pkg::seq_stat_type stat;
   ple_pkg::status_type   chk_status;
   logic                  go;
   logic                  grow;
   logic [AW-1:0]         index;
   logic [WIDTH-1:0]      taken;

   logic          accept;
   logic          pos_ok;
   logic          list_full;
   logic          list_empty;

   logic          rd_en, wr_en;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [WIDTH-1:0] rd_data, wr_data;

   assign accept     = start && !stat.busy;
   assign list_full  = (used_ff == CW'(DEPTH));
   assign list_empty = (used_ff == '0);
   assign pos_ok     = (CMPW'(req_position) != '0) && (CMPW'(req_position) < CMPW'(used_ff));

   // Full and empty checks take priority over the position check.
   always_comb begin
      chk_status = ple_pkg::ST_OK;
      go         = 1'b0;
      grow       = 1'b0;
      index      = '0;
      case (ple_pkg::command_type'(req_command))
         ple_pkg::CMD_INSERT_AT: begin
            grow = 1'b1;
            if (list_full) begin
               chk_status = ple_pkg::ST_FULL;
            end else if (!pos_ok) begin
               chk_status = ple_pkg::ST_RANGE;
            end else begin
               go    = 1'b1;
               index = AW'(req_position);
            end
         end
         ple_pkg::CMD_PUSH_FRONT: begin
            grow = 1'b1;
            if (list_full) begin
               chk_status = ple_pkg::ST_FULL;
            end else begin
               go = 1'b1;
            end
         end
         ple_pkg::CMD_PUSH_BACK: begin
            grow = 1'b1;
            if (list_full) begin
               chk_status = ple_pkg::ST_FULL;
            end else begin
               go    = 1'b1;
               index = AW'(used_ff);
            end
         end
         ple_pkg::CMD_REMOVE_AT: begin
            if (list_empty) begin
               chk_status = ple_pkg::ST_EMPTY;
            end else if (!pos_ok) begin
               chk_status = ple_pkg::ST_RANGE;
            end else begin
               go    = 1'b1;
               index = AW'(req_position);
            end
         end
         ple_pkg::CMD_POP_FRONT: begin
            if (list_empty) begin
               chk_status = ple_pkg::ST_EMPTY;
            end else begin
               go = 1'b1;
            end
         end
         ple_pkg::CMD_POP_BACK: begin
            if (list_empty) begin
               chk_status = ple_pkg::ST_EMPTY;
            end else begin
               go    = 1'b1;
               index = AW'(used_ff - CW'(1));
            end
         end
         default: begin
            chk_status = ple_pkg::ST_OK;
         end
      endcase
   end

   assign ctrl.start = accept && go;
   assign ctrl.grow  = grow;

   always_comb begin
      used_in = used_ff;
      if (stat.done) begin
         used_in = stat.grow ? (used_ff + CW'(1)) : (used_ff - CW'(1));
      end
      rsp_strobe_in  = (accept && !go) || stat.done;
      rsp_status_in  = (accept && !go) ? chk_status : ple_pkg::ST_OK;
      rsp_removed_in = (stat.done && !stat.grow) ? ple_pkg::VAL_W'(taken) : '0;
      rsp_length_in  = ple_pkg::LEN_W'(used_in);
      rsp_empty_in   = (used_in == '0);
      rsp_full_in    = (used_in == CW'(DEPTH));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         used_ff       <= used_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      rsp_removed_ff <= rsp_removed_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_length_ff  <= rsp_length_in;
      rsp_empty_ff   <= rsp_empty_in;
      rsp_full_ff    <= rsp_full_in;
   end

   ple_seq #(
      .DEPTH (DEPTH),
      .WIDTH (WIDTH)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .req_index (index),
      .used      (used_ff),
      .item      (WIDTH'(req_item_value)),
      .stat      (stat),
      .taken     (taken),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data)
   );

   ple_ram #(
      .DATA_W (WIDTH),
      .DEPTH  (DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign busy              = stat.busy;
   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_removed_value = rsp_removed_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_length        = rsp_length_ff;
   assign rsp_is_empty      = rsp_empty_ff;
   assign rsp_is_full       = rsp_full_ff;

endmodule

/* design/ple_checker.sv */
// ---------------------------------------------------------------------------
// ple_checker: port-level checks for the positional list engine
// Watches the request and result ports over time; bound to the core.
// ---------------------------------------------------------------------------
module ple_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input logic                       rsp_strobe,
   input logic [ple_pkg::STAT_W-1:0] rsp_status,
   input logic [ple_pkg::LEN_W-1:0]  rsp_length,
   input logic                       rsp_is_empty,
   input logic                       rsp_is_full
);

   // The end of a multi-cycle request always yields its result.
   a_done_gives_result: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> rsp_strobe)
      else $error("busy fell without a result");

   // A rejected request answers in the cycle right after it was taken.
   a_error_follows_accept: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != ple_pkg::ST_OK)) |-> $past(start && !busy))
      else $error("error result without a request taken one cycle before");

   // An empty-list rejection must report an empty list.
   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == ple_pkg::ST_EMPTY)) |->
         (rsp_is_empty && (rsp_length == '0)))
      else $error("empty status with a non-empty list");

   // The list cannot be reported empty and full together.
   a_empty_full_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_is_empty && rsp_is_full))
      else $error("list reported empty and full at once");

endmodule

bind positional_list_engine_core ple_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .rsp_strobe   (rsp_strobe),
   .rsp_status   (rsp_status),
   .rsp_length   (rsp_length),
   .rsp_is_empty (rsp_is_empty),
   .rsp_is_full  (rsp_is_full)
);

/* test/positional_list_engine_core_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// positional_list_engine_core_tb: self-checking bench for the list engine
// Sends requests through the start/busy handshake, keeps a shadow copy of
// the list to work out each expected result, and compares every strobed
// result field by field. Directed corner cases come first, then long
// randomised grow and shrink sweeps with some malformed traffic mixed in.
// ---------------------------------------------------------------------------
module positional_list_engine_core_tb;

   localparam int LIST_DEPTH  = ple_pkg::DEPTH_DEFAULT;
   localparam int STALL_LIMIT = 500;
   localparam int MAX_REPORTS = 10;

   // Codes outside the defined command set; the block must treat them as no-ops.
   localparam logic [ple_pkg::CMD_W-1:0] CMD_SPARE_LO = 3'd6;
   localparam logic [ple_pkg::CMD_W-1:0] CMD_SPARE_HI = 3'd7;

   localparam logic [ple_pkg::VAL_W-1:0] VAL_ZERO     = '0;
   localparam logic [ple_pkg::VAL_W-1:0] VAL_ALL_ONES = '1;

   typedef struct packed {
      logic [ple_pkg::VAL_W-1:0] removed_value;
      ple_pkg::status_type       status;
      logic [ple_pkg::LEN_W-1:0] length;
      logic                      is_empty;
      logic                      is_full;
   } list_result_type;

   logic                         clock          = 1'b0;
   logic                         reset          = 1'b1;
   logic                         start          = 1'b0;
   logic                         busy;
   logic [ple_pkg::CMD_W-1:0]    req_command    = '0;
   logic [ple_pkg::POS_W-1:0]    req_position   = '0;
   logic [ple_pkg::VAL_W-1:0]    req_item_value = '0;
   logic                         rsp_strobe;
   logic [ple_pkg::VAL_W-1:0]    rsp_removed_value;
   logic [ple_pkg::STAT_W-1:0]   rsp_status;
   logic [ple_pkg::LEN_W-1:0]    rsp_length;
   logic                         rsp_is_empty;
   logic                         rsp_is_full;

   // Shadow copy of the list contents and its occupancy.
   logic [ple_pkg::VAL_W-1:0]    shadow_slots [LIST_DEPTH];
   int                           shadow_count = 0;

   list_result_type              expected_results[$];
   int                           error_count    = 0;
   int                           requests_sent  = 0;
   int                           results_seen   = 0;
   int                           status_tally [4] = '{default: 0};
   int                           peak_length    = 0;
   int                           stall_cycles   = 0;
   bit                           idle_enabled   = 1'b1;

   positional_list_engine_core #(
      .DEPTH (LIST_DEPTH),
      .WIDTH (ple_pkg::VAL_W)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_command       (req_command),
      .req_position      (req_position),
      .req_item_value    (req_item_value),
      .rsp_strobe        (rsp_strobe),
      .rsp_removed_value (rsp_removed_value),
      .rsp_status        (rsp_status),
      .rsp_length        (rsp_length),
      .rsp_is_empty      (rsp_is_empty),
      .rsp_is_full       (rsp_is_full)
   );

   always #10 clock = ~clock;

   function automatic void shadow_insert(input int idx,
                                         input logic [ple_pkg::VAL_W-1:0] val);
      for (int k = shadow_count; k > idx; k--) begin
         shadow_slots[k] = shadow_slots[k-1];
      end
      shadow_slots[idx] = val;
      shadow_count++;
   endfunction

   function automatic logic [ple_pkg::VAL_W-1:0] shadow_remove(input int idx);
      logic [ple_pkg::VAL_W-1:0] taken;
      taken = shadow_slots[idx];
      for (int k = idx; k + 1 < shadow_count; k++) begin
         shadow_slots[k] = shadow_slots[k+1];
      end
      shadow_count--;
      return taken;
   endfunction

   // Applies one request to the shadow list and returns the result it should give.
   function automatic list_result_type apply_list_command(
      input logic [ple_pkg::CMD_W-1:0] cmd,
      input logic [ple_pkg::POS_W-1:0] pos,
      input logic [ple_pkg::VAL_W-1:0] val);
      list_result_type res;
      bit              pos_in_range;
      res          = '0;
      res.status   = ple_pkg::ST_OK;
      pos_in_range = (int'(pos) >= 1) && (shadow_count >= 1) &&
                     (int'(pos) <= shadow_count - 1);
      case (cmd)
         ple_pkg::CMD_INSERT_AT: begin
            if (shadow_count >= LIST_DEPTH) res.status = ple_pkg::ST_FULL;
            else if (!pos_in_range) res.status = ple_pkg::ST_RANGE;
            else shadow_insert(int'(pos), val);
         end
         ple_pkg::CMD_PUSH_FRONT: begin
            if (shadow_count >= LIST_DEPTH) res.status = ple_pkg::ST_FULL;
            else shadow_insert(0, val);
         end
         ple_pkg::CMD_PUSH_BACK: begin
            if (shadow_count >= LIST_DEPTH) res.status = ple_pkg::ST_FULL;
            else shadow_insert(shadow_count, val);
         end
         ple_pkg::CMD_REMOVE_AT: begin
            if (shadow_count == 0) res.status = ple_pkg::ST_EMPTY;
            else if (!pos_in_range) res.status = ple_pkg::ST_RANGE;
            else res.removed_value = shadow_remove(int'(pos));
         end
         ple_pkg::CMD_POP_FRONT: begin
            if (shadow_count == 0) res.status = ple_pkg::ST_EMPTY;
            else res.removed_value = shadow_remove(0);
         end
         ple_pkg::CMD_POP_BACK: begin
            if (shadow_count == 0) res.status = ple_pkg::ST_EMPTY;
            else res.removed_value = shadow_remove(shadow_count - 1);
         end
         default: begin
         end
      endcase
      res.length   = ple_pkg::LEN_W'(shadow_count);
      res.is_empty = (shadow_count == 0);
      res.is_full  = (shadow_count == LIST_DEPTH);
      return res;
   endfunction

   // Presents one request, holds it until the block takes it, then records
   // what the block should answer.
   task automatic send_request(input logic [ple_pkg::CMD_W-1:0] cmd,
                               input logic [ple_pkg::POS_W-1:0] pos,
                               input logic [ple_pkg::VAL_W-1:0] val);
      int              gap;
      list_result_type res;
      gap = idle_enabled ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_command    <= cmd;
      req_position   <= pos;
      req_item_value <= val;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      res = apply_list_command(cmd, pos, val);
      expected_results.push_back(res);
      requests_sent++;
      status_tally[res.status]++;
      if (shadow_count > peak_length) peak_length = shadow_count;
   endtask

   task automatic test_empty_list_errors();
      send_request(ple_pkg::CMD_REMOVE_AT, 5'd1, VAL_ZERO);
      send_request(ple_pkg::CMD_POP_FRONT, 5'd0, VAL_ALL_ONES);
      send_request(ple_pkg::CMD_POP_BACK, 5'd31, VAL_ZERO);
      send_request(ple_pkg::CMD_INSERT_AT, 5'd0, VAL_ALL_ONES);
      send_request(CMD_SPARE_LO, 5'd0, VAL_ALL_ONES);
      send_request(CMD_SPARE_HI, 5'd31, VAL_ALL_ONES);
   endtask

   task automatic test_single_entry();
      send_request(ple_pkg::CMD_PUSH_BACK, 5'd0, VAL_ZERO);
      send_request(ple_pkg::CMD_INSERT_AT, 5'd1, VAL_ALL_ONES);
      send_request(ple_pkg::CMD_REMOVE_AT, 5'd0, VAL_ZERO);
      // Popping the back of a one-entry list must leave it empty.
      send_request(ple_pkg::CMD_POP_BACK, 5'd0, VAL_ZERO);
   endtask

   task automatic test_fill_to_capacity();
      for (int i = 0; i < LIST_DEPTH; i++) begin
         send_request((i % 2 == 0) ? ple_pkg::CMD_PUSH_BACK : ple_pkg::CMD_PUSH_FRONT,
                      5'd16,
                      (i % 3 == 0) ? VAL_ALL_ONES : ple_pkg::VAL_W'($urandom));
      end
      // The full check must win over the bad position.
      send_request(ple_pkg::CMD_INSERT_AT, 5'd0, VAL_ALL_ONES);
      send_request(ple_pkg::CMD_PUSH_FRONT, 5'd0, VAL_ZERO);
      send_request(ple_pkg::CMD_PUSH_BACK, 5'd0, VAL_ALL_ONES);
   endtask

   task automatic test_random_traffic(input int n_items);
      logic [ple_pkg::CMD_W-1:0] cmd;
      logic [ple_pkg::POS_W-1:0] pos;
      logic [ple_pkg::VAL_W-1:0] val;
      bit                        grow;
      int                        pick;
      int                        kind;
      grow = 1'b0;
      for (int i = 0; i < n_items; i++) begin
         if (i % 40 == 0) idle_enabled = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 19) == 0) grow = !grow;
         if (grow && shadow_count == LIST_DEPTH && $urandom_range(0, 3) != 0) grow = 1'b0;
         if (!grow && shadow_count == 0 && $urandom_range(0, 3) != 0) grow = 1'b1;
         case ($urandom_range(0, 7))
            0:       val = VAL_ZERO;
            1:       val = VAL_ALL_ONES;
            default: val = ple_pkg::VAL_W'($urandom);
         endcase
         pick = $urandom_range(0, 99);
         if (pick < 85) begin
            kind = $urandom_range(0, 2);
            if (shadow_count < 2) begin
               pos = ple_pkg::POS_W'($urandom_range(0, 2));
            end else begin
               // Lean on the edges of the legal position window.
               case ($urandom_range(0, 3))
                  0:       pos = ple_pkg::POS_W'(1);
                  1:       pos = ple_pkg::POS_W'(shadow_count - 1);
                  default: pos = ple_pkg::POS_W'($urandom_range(1, shadow_count - 1));
               endcase
            end
            if (grow) begin
               cmd = (kind == 0) ? ple_pkg::CMD_INSERT_AT :
                     (kind == 1) ? ple_pkg::CMD_PUSH_FRONT : ple_pkg::CMD_PUSH_BACK;
            end else begin
               cmd = (kind == 0) ? ple_pkg::CMD_REMOVE_AT :
                     (kind == 1) ? ple_pkg::CMD_POP_FRONT : ple_pkg::CMD_POP_BACK;
            end
         end else begin
            cmd = ple_pkg::CMD_W'($urandom_range(0, 7));
            case ($urandom_range(0, 3))
               0:       pos = ple_pkg::POS_W'(0);
               1:       pos = ple_pkg::POS_W'(shadow_count);
               2:       pos = ple_pkg::POS_W'(shadow_count + 1);
               default: pos = ple_pkg::POS_W'($urandom_range(0, 31));
            endcase
         end
         send_request(cmd, pos, val);
      end
   endtask

   // Result checker: each strobed result is matched against the oldest
   // outstanding expectation.
   always @(posedge clock) begin
      list_result_type exp_res;
      if (!reset && rsp_strobe === 1'b1) begin
         results_seen++;
         if (expected_results.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
               $display("[%0t] result with no request outstanding: removed=%h status=%0d",
                        $realtime, rsp_removed_value, rsp_status);
            end
         end else begin
            exp_res = expected_results.pop_front();
            if (rsp_removed_value !== exp_res.removed_value ||
                rsp_status !== exp_res.status ||
                rsp_length !== exp_res.length || rsp_is_empty !== exp_res.is_empty ||
                rsp_is_full !== exp_res.is_full) begin
               error_count++;
               if (error_count <= MAX_REPORTS) begin
                  $display("[%0t] mismatch: expected removed=%h status=%0d len=%0d",
                           $realtime, exp_res.removed_value, exp_res.status,
                           exp_res.length);
                  $display("[%0t]           expected empty=%b full=%b",
                           $realtime, exp_res.is_empty, exp_res.is_full);
                  $display("[%0t]           actual   removed=%h status=%0d len=%0d",
                           $realtime, rsp_removed_value, rsp_status, rsp_length);
                  $display("[%0t]           actual   empty=%b full=%b",
                           $realtime, rsp_is_empty, rsp_is_full);
               end
            end
         end
      end
   end

   // Watchdog: the run is stuck if nothing moves on either channel for too long.
   always @(posedge clock) begin
      if ((start === 1'b1 && busy === 1'b0) || rsp_strobe === 1'b1) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("[%0t] watchdog: no handshake for %0d cycles", $realtime, STALL_LIMIT);
         $display("positional_list_engine_core_tb: errors");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_list_errors();
      test_single_entry();
      test_fill_to_capacity();
      test_random_traffic(1624);

      start <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (LIST_DEPTH + 4) @(posedge clock);

      $display("%0d requests, %0d results: ok %0d, bad position %0d, empty %0d, full %0d",
               requests_sent, results_seen, status_tally[ple_pkg::ST_OK],
               status_tally[ple_pkg::ST_RANGE], status_tally[ple_pkg::ST_EMPTY],
               status_tally[ple_pkg::ST_FULL]);
      $display("peak list length %0d of %0d, %0d failures", peak_length, LIST_DEPTH,
               error_count);
      if (error_count == 0) begin
         $display("positional_list_engine_core_tb: clean");
      end else begin
         $display("positional_list_engine_core_tb: errors");
      end
      $finish;
   end

endmodule
